// File: design/prde_pkg.sv
// shared types and constants for the psg register delta encoder
package prde_pkg;

  // register file geometry
  localparam int RegN  = 8;
  localparam int RegAW = 3;
  localparam int RegW  = 10;

  // register value after reset and field masks
  localparam logic [RegW-1:0] REG_RESET    = 10'h3FF;
  localparam logic [RegW-1:0] NOISE_MASK   = 10'h007;
  localparam logic [RegW-1:0] LOW_MASK     = 10'h00F;
  localparam logic [RegW-1:0] TONE_HI_MASK = 10'h3F0;

  // channel code of the noise generator
  localparam logic [1:0] NOISE_CH = 2'd3;

  // bytes that one register contributes to the delta
  typedef struct packed {
    logic       need_latch;
    logic       need_data;
    logic [7:0] latch_byte;
    logic [7:0] data_byte;
  } delta_t;

endpackage

// File: design/prde_ram.sv
// register file memory, one write and one registered read port
module prde_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [prde_pkg::RegAW-1:0]    waddr,
  input  logic [prde_pkg::RegW-1:0]     wdata,
  input  logic                          re,
  input  logic [prde_pkg::RegAW-1:0]    raddr,
  output logic [prde_pkg::RegW-1:0]     rdata
);

  logic [prde_pkg::RegW-1:0] mem [prde_pkg::RegN];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data registered and available in the cycle after the address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/prde_delta.sv
// compares one target register with its reference and forms the write bytes
module prde_delta (
  input  logic [prde_pkg::RegAW-1:0] idx,
  input  logic [prde_pkg::RegW-1:0]  tgt_raw,
  input  logic                       tgt_vld,
  input  logic [prde_pkg::RegW-1:0]  ref_raw,
  input  logic                       ref_vld,
  output prde_pkg::delta_t           delta
);

  logic [1:0]                ch;
  logic                      vol;
  logic [prde_pkg::RegW-1:0] mask;
  logic [prde_pkg::RegW-1:0] tv;
  logic [prde_pkg::RegW-1:0] rv;
  logic                      none_vld;
  logic                      same_all;
  logic                      same_lo;
  logic                      same_hi;
  logic                      lo_only;

  assign ch  = idx[2:1];
  assign vol = idx[0];

  // compared view of the register
  always_comb begin
    if (vol) begin
      mask = prde_pkg::LOW_MASK;
    end else if (ch == prde_pkg::NOISE_CH) begin
      mask = prde_pkg::NOISE_MASK;
    end else begin
      mask = {prde_pkg::RegW{1'b1}};
    end
  end

  assign tv = tgt_raw & mask;
  assign rv = ref_raw & mask;

  // equality rules, an untouched pair counts as equal
  assign none_vld = !tgt_vld && !ref_vld;
  assign same_all = none_vld || (ref_vld && (tv == rv));
  assign same_lo  = none_vld || (ref_vld && (tv[3:0] == rv[3:0]));
  assign same_hi  = none_vld || (ref_vld && (tv[9:4] == rv[9:4]));
  assign lo_only  = !vol && !same_lo && same_hi;

  // latch byte for any change, data byte for a tone whose high bits moved
  always_comb begin
    delta.need_latch = !same_all;
    delta.need_data  = !same_all && !vol && (ch != prde_pkg::NOISE_CH) && !lo_only;
    delta.latch_byte = {1'b1, ch, vol, tv[3:0]};
    delta.data_byte  = {2'b00, tv[9:4]};
  end

endmodule

// File: design/psg_register_delta_encoder_core.sv
// top level of the psg register delta encoder
//
// Write bytes are decoded into an eight-entry target register file held in a
// registered-read RAM; each write item is a read, then a modify and write back,
// which is the read-modify-write loop on the target RAM. An end-of-frame item
// walks the eight registers through the target and reference RAMs, one register
// per cycle while no byte is emitted, then closes the frame in a last state; it
// holds the input until done and sends n bytes, n from 0 to 11. The last byte of
// a frame is held back in a pending register so it can carry out_is_last; the
// output register lets the next item be taken while a byte still waits on
// out_stall, and emission pauses only while the output is full.
module psg_register_delta_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_write_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_FCMP  = 3'd2;
  localparam logic [2:0] S_FEMIT = 3'd3;
  localparam logic [2:0] S_FLAST = 3'd4;

  localparam logic [prde_pkg::RegAW-1:0] IDX_LAST = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [prde_pkg::RegAW-1:0]   idx_r, idx_nxt;
  logic [1:0]                   lat_ch_r, lat_ch_nxt;
  logic                         lat_vol_r, lat_vol_nxt;
  logic [prde_pkg::RegN-1:0]    tgt_vld_r, tgt_vld_nxt;
  logic [prde_pkg::RegN-1:0]    ref_vld_r, ref_vld_nxt;
  logic [prde_pkg::RegAW-1:0]   wr_addr_r;
  logic [prde_pkg::RegW-1:0]    wr_mask_r;
  logic [prde_pkg::RegW-1:0]    wr_bits_r;
  prde_pkg::delta_t             delta_r;
  logic                         sel_r, sel_nxt;
  logic                         pend_vld_r, pend_vld_nxt;
  logic [7:0]                   pend_byte_r, pend_byte_nxt;
  logic                         out_vld_r;
  logic [7:0]                   out_byte_r;
  logic                         out_last_r;

  logic                         in_xfer;
  logic                         out_free;
  logic                         push;
  logic                         push_last;
  logic [7:0]                   push_byte;
  logic                         adv;
  logic                         step;
  logic [7:0]                   step_byte;

  logic [1:0]                   dec_ch;
  logic                         dec_vol;
  logic [prde_pkg::RegW-1:0]    dec_mask;
  logic [prde_pkg::RegW-1:0]    dec_bits;

  logic                         rd_en;
  logic [prde_pkg::RegAW-1:0]   rd_addr;
  logic                         t_we;
  logic [prde_pkg::RegW-1:0]    t_wdata;
  logic [prde_pkg::RegW-1:0]    t_rdata;
  logic [prde_pkg::RegW-1:0]    t_old;
  logic                         r_we;
  logic [prde_pkg::RegW-1:0]    r_rdata;
  prde_pkg::delta_t             delta;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  // write byte decode against the current latch
  always_comb begin
    dec_ch  = in_write_byte[7] ? in_write_byte[6:5] : lat_ch_r;
    dec_vol = in_write_byte[7] ? in_write_byte[4] : lat_vol_r;
    if (!dec_vol && (dec_ch == prde_pkg::NOISE_CH)) begin
      dec_mask = prde_pkg::NOISE_MASK;
      dec_bits = {7'd0, in_write_byte[2:0]};
    end else if (in_write_byte[7] || dec_vol) begin
      dec_mask = prde_pkg::LOW_MASK;
      dec_bits = {6'd0, in_write_byte[3:0]};
    end else begin
      dec_mask = prde_pkg::TONE_HI_MASK;
      dec_bits = {in_write_byte[5:0], 4'd0};
    end
  end

  // target write-back merges the new bits into the old value
  assign t_old   = tgt_vld_r[wr_addr_r] ? t_rdata : prde_pkg::REG_RESET;
  assign t_wdata = (t_old & ~wr_mask_r) | wr_bits_r;
  assign t_we    = (state_r == S_WRITE);

  // reference takes the target value of each touched register during the walk
  assign r_we = (state_r == S_FCMP) && tgt_vld_r[idx_r];

  // per-register compare
  prde_delta u_delta (
    .idx     (idx_r),
    .tgt_raw (t_rdata),
    .tgt_vld (tgt_vld_r[idx_r]),
    .ref_raw (r_rdata),
    .ref_vld (ref_vld_r[idx_r]),
    .delta   (delta)
  );

  // byte emission step through the one-deep hold stage
  assign step_byte = sel_r ? delta_r.data_byte : delta_r.latch_byte;
  assign step      = (state_r == S_FEMIT) && (!pend_vld_r || out_free);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    lat_ch_nxt   = lat_ch_r;
    lat_vol_nxt  = lat_vol_r;
    tgt_vld_nxt  = tgt_vld_r;
    ref_vld_nxt  = ref_vld_r;
    sel_nxt      = sel_r;
    pend_vld_nxt = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    push         = 1'b0;
    push_last    = 1'b0;
    push_byte    = pend_byte_r;
    adv          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_req_type) begin
            idx_nxt   = '0;
            state_nxt = S_FCMP;
          end else begin
            lat_ch_nxt  = dec_ch;
            lat_vol_nxt = dec_vol;
            state_nxt   = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        tgt_vld_nxt[wr_addr_r] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FCMP: begin
        ref_vld_nxt[idx_r] = ref_vld_r[idx_r] || tgt_vld_r[idx_r];
        sel_nxt = 1'b0;
        if (delta.need_latch) begin
          state_nxt = S_FEMIT;
        end else begin
          adv = 1'b1;
        end
      end
      S_FEMIT: begin
        if (step) begin
          push          = pend_vld_r;
          pend_vld_nxt  = 1'b1;
          pend_byte_nxt = step_byte;
          if (!sel_r && delta_r.need_data) begin
            sel_nxt = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
      end
      S_FLAST: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // move on to the next register or close the frame
    if (adv) begin
      if (idx_r == IDX_LAST) begin
        state_nxt = S_FLAST;
      end else begin
        idx_nxt   = idx_r + 3'd1;
        state_nxt = S_FCMP;
      end
    end
  end

  // shared read address of both memories
  always_comb begin
    rd_en   = in_xfer || (adv && (idx_r != IDX_LAST));
    if (in_xfer) begin
      rd_addr = in_req_type ? '0 : {dec_ch, dec_vol};
    end else begin
      rd_addr = idx_r + 3'd1;
    end
  end

  prde_ram u_tgt_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (wr_addr_r),
    .wdata (t_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (t_rdata)
  );

  prde_ram u_ref_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (idx_r),
    .wdata (t_rdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (r_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      lat_ch_r   <= '0;
      lat_vol_r  <= 1'b0;
      tgt_vld_r  <= '0;
      ref_vld_r  <= '0;
      sel_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      lat_ch_r   <= lat_ch_nxt;
      lat_vol_r  <= lat_vol_nxt;
      tgt_vld_r  <= tgt_vld_nxt;
      ref_vld_r  <= ref_vld_nxt;
      sel_r      <= sel_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    if (in_xfer) begin
      wr_addr_r <= {dec_ch, dec_vol};
      wr_mask_r <= dec_mask;
      wr_bits_r <= dec_bits;
    end
    if (state_r == S_FCMP) begin
      delta_r <= delta;
    end
    if (push) begin
      out_byte_r <= push_byte;
      out_last_r <= push_last;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;

endmodule

// File: design/prde_checker.sv
// port-level checks for the psg register delta encoder
module prde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_req_type,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_last
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_is_last))
    else $error("stalled result changed");

  // every accepted item makes the input busy, so items are never taken back to back
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // a register write never starts a result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_req_type |=> !$rose(out_valid))
    else $error("result appeared after a write item");

  // data bytes carry only six tone bits
  a_data_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte[7] || !out_byte[6]))
    else $error("malformed data byte");

endmodule

bind psg_register_delta_encoder_core prde_checker u_prde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .out_is_last (out_is_last)
);

// File: bench/testbench.sv
// self-checking testbench for the psg register delta encoder core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int IDLE_PCT      = 36;
  localparam int RANDOM_ITEMS  = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 30;

  localparam logic                     REQ_WRITE  = 1'b0;
  localparam logic                     REQ_FRAME  = 1'b1;
  localparam logic [7:0]               LATCH_FLAG = 8'h80;
  localparam logic [prde_pkg::RegW-1:0] FULL_MASK = 10'h3FF;

  // register number within the file
  typedef logic [prde_pkg::RegAW-1:0] reg_idx_t;

  // one psg write byte of a frame delta
  typedef struct packed {
    logic [7:0] wr_byte;
    logic       is_last;
  } psg_write_t;

  // tracks target and reference register files, queues the delta bytes
  class psg_delta_scoreboard;
    logic [prde_pkg::RegW-1:0] tgt_regs [prde_pkg::RegN];
    logic                      tgt_valid [prde_pkg::RegN];
    logic [prde_pkg::RegW-1:0] ref_regs [prde_pkg::RegN];
    logic                      ref_valid [prde_pkg::RegN];
    logic [1:0]                latch_ch;
    logic                      latch_vol;
    psg_write_t                expected_writes [$];
    int                        mismatches;
    int                        checked;
    int                        longest_delta;

    function new();
      for (int i = 0; i < prde_pkg::RegN; i++) begin
        tgt_regs[i]  = prde_pkg::REG_RESET;
        tgt_valid[i] = 1'b0;
        ref_regs[i]  = prde_pkg::REG_RESET;
        ref_valid[i] = 1'b0;
      end
      latch_ch      = '0;
      latch_vol     = 1'b0;
      mismatches    = 0;
      checked       = 0;
      longest_delta = 0;
    endfunction

    function int outstanding();
      return expected_writes.size();
    endfunction

    // compared bits: volume 3:0, noise 2:0, tone 9:0
    function logic [prde_pkg::RegW-1:0] field_of(logic [prde_pkg::RegW-1:0] v, reg_idx_t r);
      if (r[0])
        return v & prde_pkg::LOW_MASK;
      if (r[2:1] == prde_pkg::NOISE_CH)
        return v & prde_pkg::NOISE_MASK;
      return v;
    endfunction

    // both never written counts as equal, else reference must be valid and match
    function bit part_same(reg_idx_t r, logic [prde_pkg::RegW-1:0] a,
                           logic [prde_pkg::RegW-1:0] b,
                           logic [prde_pkg::RegW-1:0] mask);
      if (!ref_valid[r] && !tgt_valid[r])
        return 1'b1;
      return ref_valid[r] && ((a & mask) == (b & mask));
    endfunction

    function void write_bits(logic [prde_pkg::RegW-1:0] mask,
                             logic [prde_pkg::RegW-1:0] bits);
      reg_idx_t r;
      r = {latch_ch, latch_vol};
      tgt_regs[r]  = (tgt_regs[r] & ~mask) | (bits & mask);
      tgt_valid[r] = 1'b1;
    endfunction

    // called for every accepted input transfer
    function void note_transfer(logic req, logic [7:0] b);
      reg_idx_t                  r;
      logic [prde_pkg::RegW-1:0] tv;
      logic [prde_pkg::RegW-1:0] rv;
      logic [7:0]                latch;
      psg_write_t                delta [$];
      psg_write_t                w;
      // register write byte: decode into the target file
      if (req == REQ_WRITE) begin
        if (b[7]) begin
          latch_ch  = b[6:5];
          latch_vol = b[4];
        end
        if (!latch_vol && latch_ch == prde_pkg::NOISE_CH)
          write_bits(prde_pkg::NOISE_MASK, {3'b000, b[6:0]});
        else if (b[7] || latch_vol)
          write_bits(prde_pkg::LOW_MASK, {3'b000, b[6:0]});
        else
          write_bits(prde_pkg::TONE_HI_MASK, {b[5:0], 4'b0000});
        return;
      end
      // frame end: walk registers in order and build the minimal delta
      w.is_last = 1'b0;
      for (int i = 0; i < prde_pkg::RegN; i++) begin
        r     = reg_idx_t'(i);
        tv    = field_of(tgt_regs[r], r);
        rv    = field_of(ref_regs[r], r);
        latch = {1'b1, r, tv[3:0]};
        if (!r[0] && !part_same(r, rv, tv, prde_pkg::LOW_MASK) &&
            part_same(r, rv, tv, prde_pkg::TONE_HI_MASK)) begin
          w.wr_byte = latch;
          delta.push_back(w);
        end else if (!part_same(r, rv, tv, FULL_MASK)) begin
          w.wr_byte = latch;
          delta.push_back(w);
          if (!r[0] && r[2:1] != prde_pkg::NOISE_CH) begin
            w.wr_byte = {2'b00, tv[9:4]};
            delta.push_back(w);
          end
        end
      end
      if (delta.size() > 0) begin
        w = delta.pop_back();
        w.is_last = 1'b1;
        delta.push_back(w);
      end
      if (delta.size() > longest_delta)
        longest_delta = delta.size();
      foreach (delta[k])
        expected_writes.push_back(delta[k]);
      // reference now follows the target
      for (int i = 0; i < prde_pkg::RegN; i++) begin
        ref_regs[i]  = tgt_regs[i];
        ref_valid[i] = ref_valid[i] || tgt_valid[i];
      end
    endfunction

    // called for every accepted result transfer
    function void check_transfer(logic [7:0] b, logic last);
      psg_write_t w;
      if (expected_writes.size() == 0) begin
        $error("unexpected result transfer: out_byte %02h out_is_last %0b", b, last);
        mismatches++;
        return;
      end
      w = expected_writes.pop_front();
      checked++;
      if (b !== w.wr_byte) begin
        $error("out_byte: expected %02h, actual %02h", w.wr_byte, b);
        mismatches++;
      end
      if (last !== w.is_last) begin
        $error("out_is_last: expected %0b, actual %0b", w.is_last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [7:0] in_write_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_last;

  psg_delta_scoreboard delta_sb;
  logic hold_request;
  logic no_gaps;
  int   n_writes;
  int   n_frames;

  psg_register_delta_encoder_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_write_byte(in_write_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_is_last  (out_is_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // offer one item, with random idle cycles first, and wait for its transfer
  task automatic send_item(logic req, logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_write_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    delta_sb.note_transfer(req, b);
    if (req == REQ_FRAME)
      n_frames++;
    else
      n_writes++;
  endtask

  // a run of write bytes closed by a frame end; heavy touches every register
  task automatic send_frame(int n_wr, bit heavy);
    if (heavy) begin
      for (int r = 0; r < prde_pkg::RegN; r++) begin
        send_item(REQ_WRITE, LATCH_FLAG | {1'b0, reg_idx_t'(r), 4'($urandom_range(15))});
        if (r % 2 == 0 && r < 6)
          send_item(REQ_WRITE, 8'($urandom_range(63)));
      end
    end else begin
      for (int i = 0; i < n_wr; i++) begin
        if ($urandom_range(99) < 80) begin
          send_item(REQ_WRITE, LATCH_FLAG | 8'($urandom_range(127)));
          if ($urandom_range(1) == 1)
            send_item(REQ_WRITE, 8'($urandom_range(127)));
        end else begin
          send_item(REQ_WRITE, 8'($urandom_range(255)));
        end
      end
    end
    send_item(REQ_FRAME, 8'($urandom_range(255)));
  endtask

  // stop offering until every queued delta byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (delta_sb.outstanding() > 0);
  endtask

  // result side: random stall, one long hold-off on request
  initial begin : result_sink
    int held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // check every result transfer
  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        delta_sb.check_transfer(out_byte, out_is_last);
    end
  end

  // give up when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int start_items;
    int frame_idx;
    delta_sb      = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_WRITE;
    in_write_byte = '0;
    hold_request  = 1'b0;
    no_gaps       = 1'b0;
    n_writes      = 0;
    n_frames      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty delta right after reset
    send_item(REQ_FRAME, 8'hFF);
    // data before any latch lands in tone 0 high bits
    send_item(REQ_WRITE, 8'h3F);
    send_item(REQ_FRAME, 8'h00);
    // tone low nibble only changes
    send_item(REQ_WRITE, 8'h80);
    send_item(REQ_FRAME, 8'hA5);
    // noise latch and data keep bits 2:0 only
    send_item(REQ_WRITE, 8'hEC);
    send_item(REQ_WRITE, 8'h7B);
    // volume latch then volume data
    send_item(REQ_WRITE, 8'hBA);
    send_item(REQ_WRITE, 8'h45);
    // tone 2 low and high parts, channel 3 volume
    send_item(REQ_WRITE, 8'hCF);
    send_item(REQ_WRITE, 8'h00);
    send_item(REQ_WRITE, 8'hFF);
    send_item(REQ_FRAME, 8'h5A);
    // rewrite an unchanged value: no delta
    send_item(REQ_WRITE, 8'hB5);
    send_item(REQ_FRAME, 8'h01);
    wait_drained();

    // random frames, gap-free stretch, hold-off burst, periodic drain pauses
    start_items = n_writes + n_frames;
    frame_idx   = 0;
    while (n_writes + n_frames - start_items < RANDOM_ITEMS) begin
      no_gaps = (frame_idx >= 5 && frame_idx < 15);
      if (frame_idx == 20) begin
        hold_request = 1'b1;
        repeat (4) send_frame(0, 1'b1);
      end else begin
        send_frame($urandom_range(8), 1'b0);
      end
      if (frame_idx % 9 == 8)
        wait_drained();
      frame_idx++;
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    // drain and let the block settle
    while (delta_sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d write bytes and %0d frame ends, %0d delta bytes compared",
             n_writes, n_frames, delta_sb.checked);
    $display("largest delta %0d bytes, one output hold-off of %0d cycles",
             delta_sb.longest_delta, HOLD_CYCLES);
    if (delta_sb.mismatches == 0 && delta_sb.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
design/prde_pkg.sv
design/prde_ram.sv
design/prde_delta.sv
design/psg_register_delta_encoder_core.sv
design/prde_checker.sv
bench/testbench.sv
